// File: rtl/core/fdasc_pkg.sv
// Package with constants and types for the fixed-point to decimal text converter.
`timescale 1ns / 1ps

package fdasc_pkg;

  // Default number format: Q31.16 in a 48-bit input word.
  localparam int INT_BITS_DEF  = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int VALUE_W       = 48;

  // Character and register widths.
  localparam int CHAR_W   = 7;
  localparam int PLACES_W = 3;

  // Fraction digit count: reset value and saturation limits.
  localparam logic [PLACES_W-1:0] PLACES_RESET = 3'd3;
  localparam logic [PLACES_W-1:0] PLACES_MIN   = 3'd1;
  localparam logic [PLACES_W-1:0] PLACES_MAX   = 3'd4;

  // ASCII codes that the converter emits.
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CHAR_POINT = 7'h2E;

  // Sequencer states, one-hot.
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CONV  = 6'b000010,
    ST_SIGN  = 6'b000100,
    ST_INT   = 6'b001000,
    ST_POINT = 6'b010000,
    ST_FRAC  = 6'b100000
  } fdasc_state_t;

endpackage

// File: rtl/core/fixed_to_decimal_ascii.sv
// Converter from a signed fixed-point number to its decimal ASCII text.
//
//   Channel   Direction  Handshake                  Payload
//   input     in         in_valid / in_ready        value
//   output    out        out_valid / out_ready      char_code, last_char
//   config    in         cfg_wr_en                  cfg_wr_data
//
// An item is loaded, then the integer part is converted one double-dabble bit
// per cycle; the sequencer then steps through each of the ND BCD digit positions
// (skipped leading zeros included) and emits the sign, the point and the fraction
// digits, the point and fraction digits only when the fraction is nonzero.
// A stalled output holds the sequencer until the character register drains.
// Synchronous active-high reset idles the sequencer and sets the fraction
// digit count to three. in_ready is high only while the sequencer is idle.
`timescale 1ns / 1ps

module fixed_to_decimal_ascii #(
  parameter int INT_BITS  = fdasc_pkg::INT_BITS_DEF,
  parameter int FRAC_BITS = fdasc_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // Input channel
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [fdasc_pkg::VALUE_W-1:0]  value,
  // Output channel
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic        [fdasc_pkg::CHAR_W-1:0]   char_code,
  output logic                                  last_char,
  // Configuration port
  input  logic                                  cfg_wr_en,
  input  logic        [fdasc_pkg::PLACES_W-1:0] cfg_wr_data
);

  localparam int TOTAL  = INT_BITS + FRAC_BITS;
  localparam int EXT_W  = (TOTAL > fdasc_pkg::VALUE_W) ? TOTAL : fdasc_pkg::VALUE_W;
  // Decimal digits needed for the largest integer magnitude.
  localparam int ND     = (INT_BITS * 30103) / 100000 + 1;
  localparam int BCD_W  = ND * 4;
  localparam int CNT_W  = $clog2(INT_BITS + 1);
  localparam int DIG_W  = $clog2(ND + 1);
  localparam int PROD_W = FRAC_BITS + 4;

  fdasc_pkg::fdasc_state_t state;

  logic [fdasc_pkg::PLACES_W-1:0] places_cfg;
  logic [fdasc_pkg::PLACES_W-1:0] places;
  logic [fdasc_pkg::PLACES_W-1:0] places_sat;
  logic [fdasc_pkg::PLACES_W-1:0] frac_cnt;
  logic                           negative;
  logic [INT_BITS-1:0]            ishift;
  logic [FRAC_BITS-1:0]           frac;
  logic [BCD_W-1:0]               bcd;
  logic [BCD_W-1:0]               bcd_adj;
  logic [BCD_W-1:0]               bcd_next;
  logic [CNT_W-1:0]               bit_cnt;
  logic [DIG_W-1:0]               dig_cnt;
  logic                           started;

  logic signed [EXT_W-1:0]        value_ext;
  logic [TOTAL-1:0]               raw;
  logic [TOTAL-1:0]               mag;
  logic [PROD_W-1:0]              prod;
  logic [3:0]                     frac_digit;
  logic [FRAC_BITS-1:0]           frac_next;
  logic [3:0]                     top_digit;
  logic                           last_dig;
  logic                           slot_free;
  logic                           out_load;

  // Sign-extend the input and take the magnitude in the number's own width.
  assign value_ext = EXT_W'(value);
  assign raw       = value_ext[TOTAL-1:0];
  assign mag       = raw[TOTAL-1] ? (~raw + TOTAL'(1)) : raw;

  // Clamp the configured fraction digit count to its meaningful range.
  always_comb begin
    priority if (places_cfg < fdasc_pkg::PLACES_MIN) begin
      places_sat = fdasc_pkg::PLACES_MIN;
    end else if (places_cfg > fdasc_pkg::PLACES_MAX) begin
      places_sat = fdasc_pkg::PLACES_MAX;
    end else begin
      places_sat = places_cfg;
    end
  end

  // Double-dabble step: add three to every digit of five or more,
  // then shift in the next integer bit.
  always_comb begin
    bcd_adj = bcd;
    for (int i = 0; i < ND; i++) begin
      if (bcd[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
      end
    end
    bcd_next = {bcd_adj[BCD_W-2:0], ishift[INT_BITS-1]};
  end

  // Fraction step: times ten as two shifts and an add; the carry-out is the digit.
  assign prod       = (PROD_W'(frac) << 3) + (PROD_W'(frac) << 1);
  assign frac_digit = prod[PROD_W-1:FRAC_BITS];
  assign frac_next  = prod[FRAC_BITS-1:0];

  assign top_digit = bcd[BCD_W-1 -: 4];
  assign last_dig  = (dig_cnt == DIG_W'(ND - 1));
  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == fdasc_pkg::ST_IDLE);

  // A character is loaded whenever a printing state finds the register free, except for a skipped leading zero.
  assign out_load = slot_free &&
                    ((state == fdasc_pkg::ST_SIGN) || (state == fdasc_pkg::ST_POINT) ||
                     (state == fdasc_pkg::ST_FRAC) ||
                     ((state == fdasc_pkg::ST_INT) &&
                      (started || last_dig || (top_digit != 4'd0))));

  // Sequencer, working registers and the output character register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= fdasc_pkg::ST_IDLE;
      out_valid  <= 1'b0;
      places_cfg <= fdasc_pkg::PLACES_RESET;
    end else begin
      if (cfg_wr_en) begin
        places_cfg <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        fdasc_pkg::ST_IDLE: begin
          if (in_valid) begin
            negative <= raw[TOTAL-1];
            ishift   <= mag[TOTAL-1:FRAC_BITS];
            frac     <= mag[FRAC_BITS-1:0];
            places   <= places_sat;
            bcd      <= '0;
            bit_cnt  <= '0;
            state    <= fdasc_pkg::ST_CONV;
          end
        end

        fdasc_pkg::ST_CONV: begin
          bcd     <= bcd_next;
          ishift  <= ishift << 1;
          bit_cnt <= bit_cnt + CNT_W'(1);
          if (bit_cnt == CNT_W'(INT_BITS - 1)) begin
            dig_cnt <= '0;
            started <= 1'b0;
            state   <= negative ? fdasc_pkg::ST_SIGN : fdasc_pkg::ST_INT;
          end
        end

        fdasc_pkg::ST_SIGN: begin
          if (slot_free) begin
            char_code <= fdasc_pkg::CHAR_MINUS;
            last_char <= 1'b0;
            state     <= fdasc_pkg::ST_INT;
          end
        end

        fdasc_pkg::ST_INT: begin
          // Leading zeros are dropped, but the units digit always goes out.
          if (top_digit == 4'd0 && !started && !last_dig) begin
            bcd     <= bcd << 4;
            dig_cnt <= dig_cnt + DIG_W'(1);
          end else if (slot_free) begin
            char_code <= fdasc_pkg::CHAR_ZERO + fdasc_pkg::CHAR_W'(top_digit);
            last_char <= last_dig && (frac == '0);
            started   <= 1'b1;
            bcd       <= bcd << 4;
            dig_cnt   <= dig_cnt + DIG_W'(1);
            if (last_dig) begin
              state <= (frac == '0) ? fdasc_pkg::ST_IDLE : fdasc_pkg::ST_POINT;
            end
          end
        end

        fdasc_pkg::ST_POINT: begin
          if (slot_free) begin
            char_code <= fdasc_pkg::CHAR_POINT;
            last_char <= 1'b0;
            frac_cnt  <= '0;
            state     <= fdasc_pkg::ST_FRAC;
          end
        end

        fdasc_pkg::ST_FRAC: begin
          if (slot_free) begin
            char_code <= fdasc_pkg::CHAR_ZERO + fdasc_pkg::CHAR_W'(frac_digit);
            last_char <= (frac_cnt == places - 3'd1);
            frac      <= frac_next;
            frac_cnt  <= frac_cnt + 3'd1;
            if (frac_cnt == places - 3'd1) begin
              state <= fdasc_pkg::ST_IDLE;
            end
          end
        end

        default: begin
          state <= fdasc_pkg::ST_IDLE;
        end
      endcase
    end
  end

endmodule
